[rtl/core/hsbrgb_pkg.sv]
`timescale 1ns / 1ps
package hsbrgb_pkg;

  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned LEVEL_BITS_DEF = 4;
  localparam int unsigned PIPE_LATENCY   = 5;

  // colour sector taken from the top bits of hue * 6
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sec_t;

  typedef struct packed {
    logic valid;
    logic gray;
    sec_t sector;
  } ctl_t;

  typedef logic [CHAN_W-1:0] chan_t;

endpackage

[rtl/core/hsb_to_rgb_pwm_levels_core.sv]
// hsb to rgb drive level converter
//
// input channel: a colour beat (in_hue, in_saturation, in_brightness) is taken
// at each rising edge where start is high and busy is low. busy is low at all
// times except while rst_n is asserted, so one beat can enter every cycle.
// output channel: out_valid pulses for one cycle with the red, green and blue
// levels of one beat; the receiver takes every result and cannot stall.
// results leave in the order the beats entered, one result per beat.
// the result passes through five register stages: input capture, sector split,
// first multiply rank, second multiply rank, channel select into the output.
// throughput: one beat per cycle, sustained.
// reset: synchronous, active low; clears all valid bits so no result comes out
// for beats that were in flight. there is no other state.
`timescale 1ns / 1ps
module hsb_to_rgb_pwm_levels_core
  import hsbrgb_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_hue,
  input  logic [7:0]            in_saturation,
  input  logic [7:0]            in_brightness,
  output logic                  out_valid,
  output logic [LEVEL_BITS-1:0] out_red_level,
  output logic [LEVEL_BITS-1:0] out_green_level,
  output logic [LEVEL_BITS-1:0] out_blue_level
);

  logic  accept;
  ctl_t  front_ctl;
  chan_t front_off;
  chan_t front_sat;
  chan_t front_val;
  ctl_t  scale_ctl;
  chan_t scale_p;
  chan_t scale_q;
  chan_t scale_t;
  chan_t scale_val;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  hsbrgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .ctl_o      (front_ctl),
    .off_o      (front_off),
    .sat_o      (front_sat),
    .val_o      (front_val)
  );

  hsbrgb_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (front_ctl),
    .off_i (front_off),
    .sat_i (front_sat),
    .val_i (front_val),
    .ctl_o (scale_ctl),
    .p_o   (scale_p),
    .q_o   (scale_q),
    .t_o   (scale_t),
    .val_o (scale_val)
  );

  hsbrgb_mix #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (scale_ctl),
    .p_i     (scale_p),
    .q_i     (scale_q),
    .t_i     (scale_t),
    .val_i   (scale_val),
    .valid_o (out_valid),
    .red_o   (out_red_level),
    .green_o (out_green_level),
    .blue_o  (out_blue_level)
  );

endmodule

[rtl/core/hsbrgb_front.sv]
`timescale 1ns / 1ps
module hsbrgb_front
  import hsbrgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  chan_t hue,
  input  chan_t saturation,
  input  chan_t brightness,
  output ctl_t  ctl_o,
  output chan_t off_o,
  output chan_t sat_o,
  output chan_t val_o
);

  logic  valid1_r;
  chan_t hue1_r;
  chan_t sat1_r;
  chan_t val1_r;

  logic [CHAN_W+2:0] scaled;
  ctl_t              ctl_nxt;
  ctl_t              ctl_r;
  chan_t             off_r;
  chan_t             sat2_r;
  chan_t             val2_r;

  // hue * 6 as (hue << 2) + (hue << 1)
  always_comb begin
    scaled = {1'b0, hue1_r, 2'b00} + {2'b00, hue1_r, 1'b0};
    ctl_nxt.valid  = valid1_r;
    ctl_nxt.gray   = (sat1_r == '0);
    ctl_nxt.sector = sec_t'(scaled[CHAN_W+2:CHAN_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      ctl_r.valid <= 1'b0;
    end else begin
      valid1_r    <= accept;
      ctl_r.valid <= ctl_nxt.valid;
    end
    hue1_r       <= hue;
    sat1_r       <= saturation;
    val1_r       <= brightness;
    ctl_r.gray   <= ctl_nxt.gray;
    ctl_r.sector <= ctl_nxt.sector;
    off_r        <= scaled[CHAN_W-1:0];
    sat2_r       <= sat1_r;
    val2_r       <= val1_r;
  end

  assign ctl_o = ctl_r;
  assign off_o = off_r;
  assign sat_o = sat2_r;
  assign val_o = val2_r;

endmodule

[rtl/core/hsbrgb_scale.sv]
`timescale 1ns / 1ps
module hsbrgb_scale
  import hsbrgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_i,
  input  chan_t off_i,
  input  chan_t sat_i,
  input  chan_t val_i,
  output ctl_t  ctl_o,
  output chan_t p_o,
  output chan_t q_o,
  output chan_t t_o,
  output chan_t val_o
);

  localparam chan_t       FULL   = '1;
  localparam int unsigned PROD_W = 2*CHAN_W;

  logic [2*CHAN_W-1:0] p_prod;
  logic [2*CHAN_W-1:0] qk_prod;
  logic [2*CHAN_W-1:0] tk_prod;
  logic [2*CHAN_W-1:0] q_prod;
  logic [2*CHAN_W-1:0] t_prod;

  ctl_t  ctl3_r;
  chan_t p3_r;
  chan_t qk3_r;
  chan_t tk3_r;
  chan_t val3_r;

  ctl_t  ctl4_r;
  chan_t p4_r;
  chan_t q4_r;
  chan_t t4_r;
  chan_t val4_r;

  // first rank: p and the saturation terms of q and t
  always_comb begin
    p_prod  = PROD_W'(val_i) * PROD_W'(FULL - sat_i);
    qk_prod = PROD_W'(sat_i) * PROD_W'(off_i);
    tk_prod = PROD_W'(sat_i) * PROD_W'(FULL - off_i);
  end

  // second rank: brightness scaling of q and t
  always_comb begin
    q_prod = PROD_W'(val3_r) * PROD_W'(FULL - qk3_r);
    t_prod = PROD_W'(val3_r) * PROD_W'(FULL - tk3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= ctl_i.valid;
      ctl4_r.valid <= ctl3_r.valid;
    end
    ctl3_r.gray   <= ctl_i.gray;
    ctl3_r.sector <= ctl_i.sector;
    p3_r          <= p_prod[2*CHAN_W-1:CHAN_W];
    qk3_r         <= qk_prod[2*CHAN_W-1:CHAN_W];
    tk3_r         <= tk_prod[2*CHAN_W-1:CHAN_W];
    val3_r        <= val_i;
    ctl4_r.gray   <= ctl3_r.gray;
    ctl4_r.sector <= ctl3_r.sector;
    p4_r          <= p3_r;
    q4_r          <= q_prod[2*CHAN_W-1:CHAN_W];
    t4_r          <= t_prod[2*CHAN_W-1:CHAN_W];
    val4_r        <= val3_r;
  end

  assign ctl_o = ctl4_r;
  assign p_o   = p4_r;
  assign q_o   = q4_r;
  assign t_o   = t4_r;
  assign val_o = val4_r;

endmodule

[rtl/core/hsbrgb_mix.sv]
`timescale 1ns / 1ps
module hsbrgb_mix
  import hsbrgb_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl_i,
  input  chan_t                 p_i,
  input  chan_t                 q_i,
  input  chan_t                 t_i,
  input  chan_t                 val_i,
  output logic                  valid_o,
  output logic [LEVEL_BITS-1:0] red_o,
  output logic [LEVEL_BITS-1:0] green_o,
  output logic [LEVEL_BITS-1:0] blue_o
);

  chan_t red;
  chan_t green;
  chan_t blue;

  logic                  valid_r;
  logic [LEVEL_BITS-1:0] red_r;
  logic [LEVEL_BITS-1:0] green_r;
  logic [LEVEL_BITS-1:0] blue_r;

  always_comb begin
    red   = val_i;
    green = val_i;
    blue  = val_i;
    if (!ctl_i.gray) begin
      unique case (ctl_i.sector)
        SEC_RED_YEL: begin
          red = val_i; green = t_i;   blue = p_i;
        end
        SEC_YEL_GRN: begin
          red = q_i;   green = val_i; blue = p_i;
        end
        SEC_GRN_CYN: begin
          red = p_i;   green = val_i; blue = t_i;
        end
        SEC_CYN_BLU: begin
          red = p_i;   green = q_i;   blue = val_i;
        end
        SEC_BLU_MAG: begin
          red = t_i;   green = p_i;   blue = val_i;
        end
        default: begin
          red = val_i; green = p_i;   blue = q_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // keep the top bits of each channel
  always_ff @(posedge clk) begin
    red_r   <= red[CHAN_W-1 -: LEVEL_BITS];
    green_r <= green[CHAN_W-1 -: LEVEL_BITS];
    blue_r  <= blue[CHAN_W-1 -: LEVEL_BITS];
  end

  assign valid_o = valid_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

[rtl/core/hsbrgb_chk.sv]
`timescale 1ns / 1ps
module hsbrgb_chk
  import hsbrgb_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [7:0]            in_saturation,
  input logic [7:0]            in_brightness,
  input logic                  out_valid,
  input logic [LEVEL_BITS-1:0] out_red_level,
  input logic [LEVEL_BITS-1:0] out_green_level,
  input logic [LEVEL_BITS-1:0] out_blue_level
);

  a_beat_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted beat gave no result");

  a_result_has_beat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without an accepted beat");

  a_gray_equal : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_saturation, 5) == 8'd0) |->
      (out_red_level == out_green_level && out_green_level == out_blue_level))
    else $error("gray beat gave unequal levels");

  a_gray_level : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_saturation, 5) == 8'd0) |->
      (out_red_level == $past(in_brightness[7 -: LEVEL_BITS], 5)))
    else $error("gray beat level differs from brightness");

endmodule

bind hsb_to_rgb_pwm_levels_core hsbrgb_chk #(
  .LEVEL_BITS (LEVEL_BITS)
) u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_saturation   (in_saturation),
  .in_brightness   (in_brightness),
  .out_valid       (out_valid),
  .out_red_level   (out_red_level),
  .out_green_level (out_green_level),
  .out_blue_level  (out_blue_level)
);

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import hsbrgb_pkg::*;

  localparam int unsigned LVL_W      = LEVEL_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } levels_t;

  class hsb_level_checker;
    levels_t     pending_levels[$];
    int unsigned beats_seen;
    int unsigned results_checked;
    int unsigned gray_beats;
    int unsigned sector_hits[6];
    int unsigned mismatches;

    function new();
      beats_seen      = 0;
      results_checked = 0;
      gray_beats      = 0;
      mismatches      = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    function logic [LVL_W-1:0] to_level(int unsigned chan);
      logic [CHAN_W-1:0] c;
      c = chan[CHAN_W-1:0];
      return c[CHAN_W-1 -: LVL_W];
    endfunction

    function levels_t hsb_to_levels(logic [7:0] hue, logic [7:0] sat, logic [7:0] bri);
      levels_t     lv;
      logic [10:0] scaled;
      sec_t        sec;
      int unsigned off, s, v, p, q, t, r, g, b;
      s      = 32'(sat);
      v      = 32'(bri);
      scaled = 11'(hue) * 11'd6;
      sec    = sec_t'(scaled[10:8]);
      off    = 32'(scaled[7:0]);
      p      = (v * (255 - s)) >> 8;
      q      = (v * (255 - ((s * off) >> 8))) >> 8;
      t      = (v * (255 - ((s * (255 - off)) >> 8))) >> 8;
      if (s == 0) begin
        r = v; g = v; b = v;
      end else begin
        case (sec)
          SEC_RED_YEL: begin r = v; g = t; b = p; end
          SEC_YEL_GRN: begin r = q; g = v; b = p; end
          SEC_GRN_CYN: begin r = p; g = v; b = t; end
          SEC_CYN_BLU: begin r = p; g = q; b = v; end
          SEC_BLU_MAG: begin r = t; g = p; b = v; end
          default: begin r = v; g = p; b = q; end
        endcase
      end
      lv.red   = to_level(r);
      lv.green = to_level(g);
      lv.blue  = to_level(b);
      return lv;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void note_beat(logic [7:0] hue, logic [7:0] sat, logic [7:0] bri);
      logic [10:0] scaled;
      scaled = 11'(hue) * 11'd6;
      beats_seen++;
      if (sat == 0) gray_beats++;
      else sector_hits[scaled[10:8]]++;
      pending_levels.push_back(hsb_to_levels(hue, sat, bri));
    endfunction

    task check_levels(logic [LVL_W-1:0] r, logic [LVL_W-1:0] g, logic [LVL_W-1:0] b);
      levels_t want;
      if (pending_levels.size() == 0) begin
        report($sformatf("result r=%0h g=%0h b=%0h with no beat pending", r, g, b));
      end else begin
        want = pending_levels.pop_front();
        results_checked++;
        if (r !== want.red || g !== want.green || b !== want.blue)
          report($sformatf("got r=%0h g=%0h b=%0h want r=%0h g=%0h b=%0h",
                           r, g, b, want.red, want.green, want.blue));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [7:0]       in_hue = '0;
  logic [7:0]       in_saturation = '0;
  logic [7:0]       in_brightness = '0;
  logic             out_valid;
  logic [LVL_W-1:0] out_red_level;
  logic [LVL_W-1:0] out_green_level;
  logic [LVL_W-1:0] out_blue_level;

  int unsigned      cycles = 0;
  hsb_level_checker levels_sb = new();

  hsb_to_rgb_pwm_levels_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_hue         (in_hue),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .out_valid      (out_valid),
    .out_red_level  (out_red_level),
    .out_green_level(out_green_level),
    .out_blue_level (out_blue_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
      levels_sb.note_beat(in_hue, in_saturation, in_brightness);
    if (rst_n === 1'b1 && out_valid === 1'b1)
      levels_sb.check_levels(out_red_level, out_green_level, out_blue_level);
  end

  task automatic send_beat(input logic [7:0] hue, input logic [7:0] sat,
                           input logic [7:0] bri, input int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned gap_pct);
    logic [7:0]  hue, sat, bri;
    int unsigned pick;
    repeat (count) begin
      hue  = 8'($urandom);
      sat  = 8'($urandom);
      bri  = 8'($urandom);
      pick = $urandom_range(99);
      // gray, full-scale and weak-saturation corners get extra weight
      if (pick < 12) sat = '0;
      else if (pick < 18) sat = 8'hff;
      else if (pick < 22) sat = 8'($urandom_range(1, 3));
      if ($urandom_range(9) == 0) bri = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
      if ($urandom_range(9) == 0) hue = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
      send_beat(hue, sat, bri, gap_pct);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gray
    send_beat(8'h00, 8'h00, 8'h00, 6);
    send_beat(8'h80, 8'h00, 8'hff, 6);
    send_beat(8'hff, 8'h00, 8'h9c, 6);
    // first hue of each sector at full saturation and brightness
    send_beat(8'd0,   8'hff, 8'hff, 6);
    send_beat(8'd43,  8'hff, 8'hff, 6);
    send_beat(8'd86,  8'hff, 8'hff, 6);
    send_beat(8'd128, 8'hff, 8'hff, 6);
    send_beat(8'd171, 8'hff, 8'hff, 6);
    send_beat(8'd214, 8'hff, 8'hff, 6);
    // last hue of a sector and top of the hue range
    send_beat(8'd42,  8'hff, 8'hff, 6);
    send_beat(8'd213, 8'hff, 8'hff, 6);
    send_beat(8'hff,  8'hff, 8'hff, 6);
    send_beat(8'hff,  8'h01, 8'hff, 6);
    // weak saturation and dark colours
    send_beat(8'd20,  8'h01, 8'h80, 6);
    send_beat(8'd100, 8'hff, 8'h00, 6);
    send_beat(8'd150, 8'h80, 8'h01, 6);
    send_beat(8'd200, 8'h7f, 8'h10, 6);
    send_beat(8'd60,  8'haa, 8'h55, 6);
    send_beat(8'd230, 8'h55, 8'haa, 6);

    run_random(190, 6);
    run_random(180, 60);
    run_random(180, 0);
    start <= 1'b0;

    while (levels_sb.pending_levels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    $display("run covered %0d beats and %0d checked results, %0d of them gray",
             levels_sb.beats_seen, levels_sb.results_checked, levels_sb.gray_beats);
    $display("sector hits: %0d %0d %0d %0d %0d %0d, mismatches %0d",
             levels_sb.sector_hits[0], levels_sb.sector_hits[1], levels_sb.sector_hits[2],
             levels_sb.sector_hits[3], levels_sb.sector_hits[4], levels_sb.sector_hits[5],
             levels_sb.mismatches);
    if (levels_sb.mismatches == 0 && levels_sb.pending_levels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
